// ===== hw/rtl/complex_tridiagonal_solver_top_macros.svh =====
// assertion macros for the complex tridiagonal solver
// used by the back-end module, no other dependencies
`ifndef COMPLEX_TRIDIAGONAL_SOLVER_TOP_MACROS_SVH
`define COMPLEX_TRIDIAGONAL_SOLVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CTSOL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTSOL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTSOL_ASSERT(label, clk, rst, prop, msg)
`define CTSOL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/ctsol_pkg.sv =====
// shared types, constants and fixed-point helpers for the tridiagonal solver
// no dependencies
`default_nettype none
package ctsol_pkg;
   localparam int MAX_ROWS    = 64;
   localparam int FRAC_BITS   = 16;
   localparam int ADDR_W      = $clog2(MAX_ROWS);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int ROW_W       = 6;
   localparam int WORD_W      = 32;
   localparam int PROD_W      = 64;
   localparam int ACC_W       = 65;
   localparam int SUM_W       = 67;
   localparam int DEN_W       = 64;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 8 * WORD_W;
   localparam int RSP_DATA_W  = ROW_W + 2 * WORD_W + STATUS_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PIVOT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [WORD_W-1:0] diag_re;
      logic signed [WORD_W-1:0] diag_im;
      logic signed [WORD_W-1:0] upper_re;
      logic signed [WORD_W-1:0] upper_im;
      logic signed [WORD_W-1:0] lower_re;
      logic signed [WORD_W-1:0] lower_im;
      logic signed [WORD_W-1:0] rhs_re;
      logic signed [WORD_W-1:0] rhs_im;
      logic                     last;
      logic                     drop;
      logic                     first;
      logic [ADDR_W-1:0]        index;
   } row_item_type;

   // saturate a wide signed value to one word
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-WORD_W:0] top;
      top = v[SUM_W-1:WORD_W-1];
      if (top == '0 || top == '1) begin
         return v[WORD_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

   // base - floor(sum / 2^frac), saturated
   function automatic logic signed [WORD_W-1:0] fold_sub(input logic signed [WORD_W-1:0] base,
                                                         input logic signed [ACC_W-1:0] sum);
      logic signed [ACC_W-1:0] sh;
      logic signed [SUM_W-1:0] diff;
      sh   = sum >>> FRAC_BITS;
      diff = $signed({{(SUM_W-WORD_W){base[WORD_W-1]}}, base})
           - $signed({{(SUM_W-ACC_W){sh[ACC_W-1]}}, sh});
      return sat_word(diff);
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/complex_tridiagonal_solver_top.sv =====
// back end per row: 18 products on one shared 32x32 multiplier, then four parallel restoring
// dividers; row zero skips the products with the row above, a zero pivot skips the dividers
// back substitution: a store read plus four products per solution row, just the read for the first
// front end and two-entry queue keep taking rows while the back end is busy, until the queue fills
// reset: synchronous, active high; clears counters, queue, state and output valid
`default_nettype none
module complex_tridiagonal_solver_top import ctsol_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request transactions, one matrix row each
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // diag_re, diag_im, upper_re, upper_im, lower_re, lower_im, rhs_re, rhs_im
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,   // last_row
   // response transactions, one solution row each, last row first
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // row_index, sol_re, sol_im, status
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast    // last_result
);
   row_item_type push_item, pop_item;
   logic         push_valid, queue_full, pop_valid, pop;

   // front: unpacks rows, counts them, marks rows that overflow the store
   ctsol_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   // decoupling queue between front and back
   ctsol_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   // back: elimination, storage, back substitution, output register
   ctsol_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/ctsol_front.sv =====
// front end: takes rows, counts them and marks overflowing rows
// depends on ctsol_pkg
`default_nettype none
module ctsol_front import ctsol_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       push_valid,
   output row_item_type               push_item,
   input  wire logic                  queue_full
);
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      push_item.diag_re  = req_tdata[0*WORD_W +: WORD_W];
      push_item.diag_im  = req_tdata[1*WORD_W +: WORD_W];
      push_item.upper_re = req_tdata[2*WORD_W +: WORD_W];
      push_item.upper_im = req_tdata[3*WORD_W +: WORD_W];
      push_item.lower_re = req_tdata[4*WORD_W +: WORD_W];
      push_item.lower_im = req_tdata[5*WORD_W +: WORD_W];
      push_item.rhs_re   = req_tdata[6*WORD_W +: WORD_W];
      push_item.rhs_im   = req_tdata[7*WORD_W +: WORD_W];
      push_item.last     = req_tlast;
      push_item.drop     = (count_ff == CNT_W'(MAX_ROWS));
      push_item.first    = (count_ff == '0);
      push_item.index    = count_ff[ADDR_W-1:0];
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (!push_item.drop) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ctsol_queue.sv =====
// short row queue between front and back end
// depends on ctsol_pkg
`default_nettype none
module ctsol_queue import ctsol_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire row_item_type push_item,
   output logic              full,
   output logic              pop_valid,
   output row_item_type      pop_item,
   input  wire logic         pop
);
   row_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_item  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ctsol_cdiv.sv =====
// restoring divider: trunc(|num| * 2^frac / den), signed and saturated
// depends on ctsol_pkg
`default_nettype none
module ctsol_cdiv import ctsol_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [ACC_W-1:0] num,
   input  wire logic [DEN_W-1:0]        den,
   output logic                         done,
   output logic signed [WORD_W-1:0]     quot
);
   localparam int WIDE_W = DEN_W + FRAC_BITS;
   localparam int HI_W   = WIDE_W - WORD_W;
   localparam int ITER_W = $clog2(WORD_W);

   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [WORD_W-1:0] low_ff, low_in, q_ff, q_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              neg_ff, neg_in, big_ff, big_in;
   logic [ACC_W-1:0]  mag_full;
   logic [WIDE_W-1:0] wide;
   logic [DEN_W-1:0]  hi_ext;
   logic [DEN_W:0]    trial;

   always_comb begin
      mag_full = num[ACC_W-1] ? (ACC_W'(0) - num) : num;
      wide     = {mag_full[DEN_W-1:0], {FRAC_BITS{1'b0}}};
      hi_ext   = {{(DEN_W-HI_W){1'b0}}, wide[WIDE_W-1:WORD_W]};
      trial    = {rem_ff, low_ff[WORD_W-1]};
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      iter_in  = iter_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      big_in   = big_ff;
      if (start) begin
         big_in  = (hi_ext >= den);
         rem_in  = (hi_ext >= den) ? '0 : hi_ext;
         low_in  = wide[WORD_W-1:0];
         den_in  = den;
         neg_in  = num[ACC_W-1];
         q_in    = '0;
         iter_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[WORD_W-2:0], 1'b0};
         end
         low_in  = {low_ff[WORD_W-2:0], 1'b0};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (big_ff || q_ff > {1'b1, {(WORD_W-1){1'b0}}}) begin
            quot = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            quot = WORD_W'(0) - q_ff;
         end
      end else begin
         if (big_ff || q_ff[WORD_W-1]) begin
            quot = {1'b0, {(WORD_W-1){1'b1}}};
         end else begin
            quot = q_ff;
         end
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      iter_ff <= iter_in;
      neg_ff  <= neg_in;
      big_ff  <= big_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ctsol_back.sv =====
// back end: forward elimination, back substitution and result register
// depends on ctsol_pkg, ctsol_cdiv and the assertion macro header
`default_nettype none
`include "complex_tridiagonal_solver_top_macros.svh"
module ctsol_back import ctsol_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  wire row_item_type           item,
   output logic                        item_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIVGO = 3'd2;
   localparam logic [2:0] ST_DIVW  = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;
   localparam logic [2:0] ST_BSRD  = 3'd5;
   localparam logic [2:0] ST_BSLD  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_LA_RR = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LA_II = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LA_RI = 5'd2;
   localparam logic [STEP_W-1:0] STEP_LA_IR = 5'd3;
   localparam logic [STEP_W-1:0] STEP_LZ_RR = 5'd4;
   localparam logic [STEP_W-1:0] STEP_LZ_II = 5'd5;
   localparam logic [STEP_W-1:0] STEP_LZ_RI = 5'd6;
   localparam logic [STEP_W-1:0] STEP_LZ_IR = 5'd7;
   localparam logic [STEP_W-1:0] STEP_DEN_R = 5'd8;
   localparam logic [STEP_W-1:0] STEP_DEN_I = 5'd9;
   localparam logic [STEP_W-1:0] STEP_NA_RR = 5'd10;
   localparam logic [STEP_W-1:0] STEP_NA_II = 5'd11;
   localparam logic [STEP_W-1:0] STEP_NA_IR = 5'd12;
   localparam logic [STEP_W-1:0] STEP_NA_RI = 5'd13;
   localparam logic [STEP_W-1:0] STEP_NZ_RR = 5'd14;
   localparam logic [STEP_W-1:0] STEP_NZ_II = 5'd15;
   localparam logic [STEP_W-1:0] STEP_NZ_IR = 5'd16;
   localparam logic [STEP_W-1:0] STEP_NZ_RI = 5'd17;
   localparam logic [STEP_W-1:0] STEP_BS_RR = 5'd18;
   localparam logic [STEP_W-1:0] STEP_BS_II = 5'd19;
   localparam logic [STEP_W-1:0] STEP_BS_RI = 5'd20;
   localparam logic [STEP_W-1:0] STEP_BS_IR = 5'd21;
   localparam int NDIV = 4;

   logic [2:0]               state_ff, state_in;
   logic [STATUS_W-1:0]      err_ff, err_in;
   logic [STEP_W-1:0]        step_ff, step_in, stop_ff, stop_in, tag_ff, tag_in;
   logic                     pvld_ff, pvld_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [WORD_W-1:0] p_re_ff, p_re_in, p_im_ff, p_im_in;
   logic signed [WORD_W-1:0] r_re_ff, r_re_in, r_im_ff, r_im_in;
   logic signed [WORD_W-1:0] u_re_ff, u_re_in, u_im_ff, u_im_in;
   logic signed [WORD_W-1:0] l_re_ff, l_re_in, l_im_ff, l_im_in;
   logic signed [WORD_W-1:0] ap_re_ff, ap_re_in, ap_im_ff, ap_im_in;
   logic signed [WORD_W-1:0] zp_re_ff, zp_re_in, zp_im_ff, zp_im_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic signed [ACC_W-1:0]  num_ff [NDIV];
   logic signed [ACC_W-1:0]  num_in [NDIV];
   logic                     last_ff, last_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in, bs_row_ff, bs_row_in;
   logic                     first_ff, first_in;
   logic signed [WORD_W-1:0] x_re_ff, x_re_in, x_im_ff, x_im_in, xn_re_ff, xn_re_in;
   logic                     rsp_vld_ff, rsp_vld_in, rsp_last_ff, rsp_last_in;
   logic [ROW_W-1:0]         rsp_row_ff, rsp_row_in;
   logic signed [WORD_W-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [STATUS_W-1:0]      rsp_st_ff, rsp_st_in;

   logic [2*WORD_W-1:0]      mem_a [MAX_ROWS];
   logic [2*WORD_W-1:0]      mem_z [MAX_ROWS];
   logic [2*WORD_W-1:0]      rd_a_ff, rd_z_ff;
   logic                     wr_en;
   logic [2*WORD_W-1:0]      wr_a, wr_z;

   logic signed [WORD_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0]  prod_x;
   logic signed [ACC_W-1:0]  acc_sum;
   logic                     div_start, rsp_load;
   logic [NDIV-1:0]          div_done;
   logic signed [WORD_W-1:0] div_q [NDIV];
   logic signed [WORD_W-1:0] a_re_w, a_im_w, z_re_w, z_im_w;
   logic signed [WORD_W-1:0] rd_a_re, rd_a_im, rd_z_re, rd_z_im;

   assign rd_a_re = rd_a_ff[WORD_W-1:0];
   assign rd_a_im = rd_a_ff[2*WORD_W-1:WORD_W];
   assign rd_z_re = rd_z_ff[WORD_W-1:0];
   assign rd_z_im = rd_z_ff[2*WORD_W-1:WORD_W];
   assign prod_x  = $signed({prod_ff[PROD_W-1], prod_ff});
   assign acc_sum = '0;

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         STEP_LA_RR: begin op_a = l_re_ff; op_b = ap_re_ff; end
         STEP_LA_II: begin op_a = l_im_ff; op_b = ap_im_ff; end
         STEP_LA_RI: begin op_a = l_re_ff; op_b = ap_im_ff; end
         STEP_LA_IR: begin op_a = l_im_ff; op_b = ap_re_ff; end
         STEP_LZ_RR: begin op_a = l_re_ff; op_b = zp_re_ff; end
         STEP_LZ_II: begin op_a = l_im_ff; op_b = zp_im_ff; end
         STEP_LZ_RI: begin op_a = l_re_ff; op_b = zp_im_ff; end
         STEP_LZ_IR: begin op_a = l_im_ff; op_b = zp_re_ff; end
         STEP_DEN_R: begin op_a = p_re_ff; op_b = p_re_ff; end
         STEP_DEN_I: begin op_a = p_im_ff; op_b = p_im_ff; end
         STEP_NA_RR: begin op_a = u_re_ff; op_b = p_re_ff; end
         STEP_NA_II: begin op_a = u_im_ff; op_b = p_im_ff; end
         STEP_NA_IR: begin op_a = u_im_ff; op_b = p_re_ff; end
         STEP_NA_RI: begin op_a = u_re_ff; op_b = p_im_ff; end
         STEP_NZ_RR: begin op_a = r_re_ff; op_b = p_re_ff; end
         STEP_NZ_II: begin op_a = r_im_ff; op_b = p_im_ff; end
         STEP_NZ_IR: begin op_a = r_im_ff; op_b = p_re_ff; end
         STEP_NZ_RI: begin op_a = r_re_ff; op_b = p_im_ff; end
         STEP_BS_RR: begin op_a = rd_a_re; op_b = x_re_ff; end
         STEP_BS_II: begin op_a = rd_a_im; op_b = x_im_ff; end
         STEP_BS_RI: begin op_a = rd_a_re; op_b = x_im_ff; end
         STEP_BS_IR: begin op_a = rd_a_im; op_b = x_re_ff; end
         default:    begin op_a = '0;      op_b = '0;       end
      endcase
   end

   always_comb begin
      a_re_w = '0;
      a_im_w = '0;
      z_re_w = '0;
      z_im_w = '0;
      if (den_ff != '0) begin
         if (!last_ff) begin
            a_re_w = div_q[0];
            a_im_w = div_q[1];
         end
         z_re_w = div_q[2];
         z_im_w = div_q[3];
      end
      wr_a = {a_im_w, a_re_w};
      wr_z = {z_im_w, z_re_w};
   end

   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign div_start = (state_ff == ST_DIVGO) && (den_ff != '0);
   assign wr_en     = (state_ff == ST_STORE);
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      err_in      = err_ff;
      step_in     = step_ff;
      stop_in     = stop_ff;
      tag_in      = tag_ff;
      pvld_in     = 1'b0;
      prod_in     = prod_ff;
      acc_re_in   = acc_re_ff;
      acc_im_in   = acc_im_ff;
      p_re_in     = p_re_ff;
      p_im_in     = p_im_ff;
      r_re_in     = r_re_ff;
      r_im_in     = r_im_ff;
      u_re_in     = u_re_ff;
      u_im_in     = u_im_ff;
      l_re_in     = l_re_ff;
      l_im_in     = l_im_ff;
      ap_re_in    = ap_re_ff;
      ap_im_in    = ap_im_ff;
      zp_re_in    = zp_re_ff;
      zp_im_in    = zp_im_ff;
      den_in      = den_ff;
      num_in      = num_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      bs_row_in   = bs_row_ff;
      first_in    = first_ff;
      x_re_in     = x_re_ff;
      x_im_in     = x_im_ff;
      xn_re_in    = xn_re_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_re_in   = rsp_re_ff;
      rsp_im_in   = rsp_im_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_last_in = rsp_last_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.drop) begin
                  // row beyond the store: dropped, flagged, last mark still honoured
                  if (err_ff == STATUS_OK) begin
                     err_in = STATUS_OVERFLOW;
                  end
                  if (item.last) begin
                     bs_row_in = ADDR_W'(MAX_ROWS - 1);
                     first_in  = 1'b1;
                     state_in  = ST_BSRD;
                  end
               end else begin
                  p_re_in  = item.diag_re;
                  p_im_in  = item.diag_im;
                  r_re_in  = item.rhs_re;
                  r_im_in  = item.rhs_im;
                  u_re_in  = item.upper_re;
                  u_im_in  = item.upper_im;
                  l_re_in  = item.lower_re;
                  l_im_in  = item.lower_im;
                  last_in  = item.last;
                  idx_in   = item.index;
                  step_in  = item.first ? STEP_DEN_R : STEP_LA_RR;
                  stop_in  = STEP_NZ_RI;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (step_ff <= stop_ff) begin
               prod_in = op_a * op_b;
               tag_in  = step_ff;
               pvld_in = 1'b1;
               step_in = step_ff + 1'b1;
            end
            if (pvld_ff) begin
               case (tag_ff)
                  STEP_LA_RR, STEP_LZ_RR, STEP_DEN_R, STEP_NA_RR, STEP_NZ_RR,
                  STEP_BS_RR: acc_re_in = prod_x;
                  STEP_LA_RI, STEP_LZ_RI, STEP_NA_IR, STEP_NZ_IR,
                  STEP_BS_RI: acc_im_in = prod_x;
                  STEP_LA_II: p_re_in  = fold_sub(p_re_ff, acc_re_ff - prod_x);
                  STEP_LA_IR: p_im_in  = fold_sub(p_im_ff, acc_im_ff + prod_x);
                  STEP_LZ_II: r_re_in  = fold_sub(r_re_ff, acc_re_ff - prod_x);
                  STEP_LZ_IR: r_im_in  = fold_sub(r_im_ff, acc_im_ff + prod_x);
                  STEP_DEN_I: den_in   = DEN_W'(acc_re_ff + prod_x);
                  STEP_NA_II: num_in[0] = acc_re_ff + prod_x;
                  STEP_NA_RI: num_in[1] = acc_im_ff - prod_x;
                  STEP_NZ_II: num_in[2] = acc_re_ff + prod_x;
                  STEP_NZ_RI: num_in[3] = acc_im_ff - prod_x;
                  STEP_BS_II: xn_re_in = fold_sub(rd_z_re, acc_re_ff - prod_x + acc_sum);
                  STEP_BS_IR: begin
                     x_im_in = fold_sub(rd_z_im, acc_im_ff + prod_x);
                     x_re_in = xn_re_ff;
                  end
                  default: begin
                  end
               endcase
               if (tag_ff == stop_ff) begin
                  state_in = (stop_ff == STEP_NZ_RI) ? ST_DIVGO : ST_EMIT;
               end
            end
         end
         ST_DIVGO: begin
            state_in = (den_ff == '0) ? ST_STORE : ST_DIVW;
         end
         ST_DIVW: begin
            if (&div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            ap_re_in = a_re_w;
            ap_im_in = a_im_w;
            zp_re_in = z_re_w;
            zp_im_in = z_im_w;
            if (den_ff == '0 && err_ff == STATUS_OK) begin
               err_in = STATUS_PIVOT;
            end
            if (last_ff) begin
               bs_row_in = idx_ff;
               first_in  = 1'b1;
               state_in  = ST_BSRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BSRD: begin
            state_in = ST_BSLD;
         end
         ST_BSLD: begin
            if (first_ff) begin
               x_re_in  = rd_z_re;
               x_im_in  = rd_z_im;
               state_in = ST_EMIT;
            end else begin
               step_in  = STEP_BS_RR;
               stop_in  = STEP_BS_IR;
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_vld_in  = 1'b1;
               rsp_row_in  = ROW_W'(bs_row_ff);
               rsp_re_in   = x_re_ff;
               rsp_im_in   = x_im_ff;
               rsp_st_in   = err_ff;
               rsp_last_in = (bs_row_ff == '0);
               if (bs_row_ff == '0) begin
                  err_in   = STATUS_OK;
                  state_in = ST_IDLE;
               end else begin
                  bs_row_in = bs_row_ff - 1'b1;
                  first_in  = 1'b0;
                  state_in  = ST_BSRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // one divider per quotient part, all sharing |p|^2
   for (genvar g = 0; g < NDIV; g++) begin : g_div
      ctsol_cdiv u_cdiv (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (num_ff[g]),
         .den   (den_ff),
         .done  (div_done[g]),
         .quot  (div_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[idx_ff] <= wr_a;
         mem_z[idx_ff] <= wr_z;
      end
      rd_a_ff <= mem_a[bs_row_ff];
      rd_z_ff <= mem_z[bs_row_ff];
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      stop_ff    <= stop_in;
      tag_ff     <= tag_in;
      prod_ff    <= prod_in;
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
      p_re_ff    <= p_re_in;
      p_im_ff    <= p_im_in;
      r_re_ff    <= r_re_in;
      r_im_ff    <= r_im_in;
      u_re_ff    <= u_re_in;
      u_im_ff    <= u_im_in;
      l_re_ff    <= l_re_in;
      l_im_ff    <= l_im_in;
      ap_re_ff   <= ap_re_in;
      ap_im_ff   <= ap_im_in;
      zp_re_ff   <= zp_re_in;
      zp_im_ff   <= zp_im_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      last_ff    <= last_in;
      idx_ff     <= idx_in;
      bs_row_ff  <= bs_row_in;
      first_ff   <= first_in;
      x_re_ff    <= x_re_in;
      x_im_ff    <= x_im_in;
      xn_re_ff   <= xn_re_in;
      rsp_row_ff <= rsp_row_in;
      rsp_re_ff  <= rsp_re_in;
      rsp_im_ff  <= rsp_im_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         err_ff     <= STATUS_OK;
         pvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         err_ff     <= err_in;
         pvld_ff    <= pvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_st_ff, rsp_im_ff, rsp_re_ff, rsp_row_ff};

   `CTSOL_ASSERT(a_last_on_row0, clock, reset, rsp_vld_ff |-> (rsp_last_ff == (rsp_row_ff == '0)), "tlast not on row zero")
   `CTSOL_ASSERT(a_div_nonzero, clock, reset, div_start |-> (den_ff != '0), "divide by zero pivot")
   `CTSOL_ASSERT(a_err_cleared, clock, reset, (rsp_load && rsp_last_in) |=> (err_ff == STATUS_OK), "error not cleared after run")
   `CTSOL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_vld_ff && state_ff == ST_IDLE), "not idle after reset")
endmodule
`default_nettype wire

// ===== sim/complex_tridiagonal_solver_top_test.sv =====
// testbench for the complex tridiagonal solver: rows are streamed in, solutions checked
// against an in-bench fixed-point thomas-algorithm predictor; depends on ctsol_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module complex_tridiagonal_solver_top_test;
   import ctsol_pkg::*;

   // expected solution row
   typedef struct {
      logic [ROW_W-1:0]         row;
      logic signed [WORD_W-1:0] re;
      logic signed [WORD_W-1:0] im;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } solution_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // diag_re, diag_im, upper_re, upper_im, lower_re, lower_im, rhs_re, rhs_im
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;   // last_row
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // row_index, sol_re, sol_im, status
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;          // last_result

   solution_type solutions_due[$];
   int           mismatches = 0;
   bit           idling = 1'b1;   // random gaps on both sides
   int           hold_cycles = 0; // receiver hold-off, counted down by the receiver

   // predictor state: modified upper (alpha) and rhs (z) per stored row
   longint alpha_re [MAX_ROWS];
   longint alpha_im [MAX_ROWS];
   longint z_re [MAX_ROWS];
   longint z_im [MAX_ROWS];
   int     rows_held = 0;
   logic [STATUS_W-1:0] run_status = STATUS_OK;

   complex_tridiagonal_solver_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- fixed-point arithmetic of the predictor ----------------

   function automatic longint clamp_word(input longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
   endfunction

   // complex product, both parts shifted down with rounding towards minus infinity
   function automatic void cplx_mul(input longint ar, ai, br, bi, output longint re, im);
      re = (ar * br - ai * bi) >>> FRAC_BITS;
      im = (ar * bi + ai * br) >>> FRAC_BITS;
   endfunction

   // one part of a quotient: (t1 + t2) * 2^frac / den, truncated and saturated
   function automatic longint quot_part(input longint t1, t2, input logic [63:0] den);
      logic signed [65:0] s;
      logic [65:0]        mag;
      logic [127:0]       q;
      s   = t1;
      s   = s + t2;
      mag = (s < 0) ? -s : s;
      q   = (128'(mag) << FRAC_BITS) / 128'(den);
      if (s < 0) begin
         if (q > 128'h80000000) return -64'sh80000000;
         return -longint'(q);
      end
      if (q > 128'h7FFFFFFF) return 64'sh7FFFFFFF;
      return longint'(q);
   endfunction

   // complex quotient n / p, zero when p is zero
   function automatic void cplx_div(input longint nr, ni, pr, pi, output longint re, im);
      logic [63:0] mr, mi, den;
      mr  = (pr < 0) ? -pr : pr;
      mi  = (pi < 0) ? -pi : pi;
      den = mr * mr + mi * mi;
      if (den == 0) begin
         re = 0;
         im = 0;
      end else begin
         re = quot_part(nr * pr, ni * pi, den);
         im = quot_part(ni * pr, -(nr * pi), den);
      end
   endfunction

   function automatic longint word_of(input logic [REQ_DATA_W-1:0] d, input int k);
      return longint'($signed(d[WORD_W*k +: WORD_W]));
   endfunction

   // forward elimination of one accepted row; back substitution on the last one
   function automatic void eliminate_row(input logic [REQ_DATA_W-1:0] d, input bit last);
      longint pr, pi, rr, ri, tr, ti, xr, xi;
      int i, r;
      solution_type s;
      if (rows_held >= MAX_ROWS) begin
         if (run_status == STATUS_OK) run_status = STATUS_OVERFLOW;
      end else begin
         i  = rows_held;
         pr = word_of(d, 0);
         pi = word_of(d, 1);
         rr = word_of(d, 6);
         ri = word_of(d, 7);
         if (i > 0) begin
            cplx_mul(word_of(d, 4), word_of(d, 5), alpha_re[i-1], alpha_im[i-1], tr, ti);
            pr = clamp_word(pr - tr);
            pi = clamp_word(pi - ti);
            cplx_mul(word_of(d, 4), word_of(d, 5), z_re[i-1], z_im[i-1], tr, ti);
            rr = clamp_word(rr - tr);
            ri = clamp_word(ri - ti);
         end
         if (pr == 0 && pi == 0 && run_status == STATUS_OK) run_status = STATUS_PIVOT;
         alpha_re[i] = 0;
         alpha_im[i] = 0;
         // alpha is kept at zero on the final row
         if (!last) cplx_div(word_of(d, 2), word_of(d, 3), pr, pi, alpha_re[i], alpha_im[i]);
         cplx_div(rr, ri, pr, pi, z_re[i], z_im[i]);
         rows_held = i + 1;
      end
      if (!last) return;
      // back substitution, emitted from the highest row down to row zero
      for (r = rows_held - 1; r >= 0; r--) begin
         if (r == rows_held - 1) begin
            xr = z_re[r];
            xi = z_im[r];
         end else begin
            cplx_mul(alpha_re[r], alpha_im[r], xr, xi, tr, ti);
            xr = clamp_word(z_re[r] - tr);
            xi = clamp_word(z_im[r] - ti);
         end
         s.row    = r[ROW_W-1:0];
         s.re     = xr[WORD_W-1:0];
         s.im     = xi[WORD_W-1:0];
         s.status = run_status;
         s.last   = (r == 0);
         solutions_due.push_back(s);
      end
      rows_held  = 0;
      run_status = STATUS_OK;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [WORD_W-1:0] signed_rand(input int unsigned lo, hi);
      logic [WORD_W-1:0] v;
      v = $urandom_range(hi, lo);
      return $urandom_range(1) ? -v : v;
   endfunction

   // diagonally dominant row, keeps the elimination well conditioned
   function automatic logic [REQ_DATA_W-1:0] tame_row();
      return {signed_rand(0, 1 << 20), signed_rand(0, 1 << 20),
              signed_rand(0, 1 << 16), signed_rand(0, 1 << 16),
              signed_rand(0, 1 << 16), signed_rand(0, 1 << 16),
              signed_rand(0, 1 << 18), signed_rand(1 << 17, 1 << 20)};
   endfunction

   function automatic logic [REQ_DATA_W-1:0] noise_row();
      return {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
   endfunction

   // offer one row, with a random gap first, and predict once it is taken
   task automatic send_row(input logic [REQ_DATA_W-1:0] d, input bit last);
      while (idling && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      eliminate_row(d, last);
   endtask

   task automatic send_run(input int rows, input bit tame);
      for (int k = 0; k < rows; k++) send_row(tame ? tame_row() : noise_row(), k == rows - 1);
   endtask

   // wait until every predicted solution has been seen, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (solutions_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // ---------------- receiver and checker ----------------

   always @(posedge clock) begin
      solution_type s;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idling && $urandom_range(99) < 28);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (solutions_due.size() == 0) begin
               $display("%0t: unexpected solution transaction %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               s = solutions_due.pop_front();
               if (rsp_tdata[ROW_W-1:0] !== s.row) begin
                  $display("%0t: row_index expected %0d actual %0d",
                           $time, s.row, rsp_tdata[ROW_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[ROW_W +: WORD_W] !== s.re) begin
                  $display("%0t: row %0d sol_re expected %h actual %h",
                           $time, s.row, s.re, rsp_tdata[ROW_W +: WORD_W]);
                  mismatches++;
               end
               if (rsp_tdata[ROW_W+WORD_W +: WORD_W] !== s.im) begin
                  $display("%0t: row %0d sol_im expected %h actual %h",
                           $time, s.row, s.im, rsp_tdata[ROW_W+WORD_W +: WORD_W]);
                  mismatches++;
               end
               if (rsp_tdata[ROW_W+2*WORD_W +: STATUS_W] !== s.status) begin
                  $display("%0t: row %0d status expected %0d actual %0d",
                           $time, s.row, s.status, rsp_tdata[ROW_W+2*WORD_W +: STATUS_W]);
                  mismatches++;
               end
               if (rsp_tlast !== s.last) begin
                  $display("%0t: row %0d last_result expected %0b actual %0b",
                           $time, s.row, s.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   // ---------------- tests ----------------

   // one-row systems: only diag and rhs count, upper and lower are ignored
   task automatic test_single_row();
      send_row({32'h0001_8000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0002_0000}, 1'b1);
      send_row({32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                32'h0, 32'h0000_0001}, 1'b1);
      drain();
   endtask

   // field extremes, saturation in products, quotients and sums
   task automatic test_extremes();
      send_row({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b0);
      send_row({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
      send_row({32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0);
      send_row({32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0000_0100}, 1'b1);
      drain();
   endtask

   // zero pivot on row zero, then a pivot that cancels exactly on row one
   task automatic test_zero_pivot();
      send_row({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                32'h0, 32'h0}, 1'b0);
      send_row({32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_0000,
                32'h0, 32'h0004_0000}, 1'b1);
      // alpha0 = 1.0, lower1 = 1.0, diag1 = 1.0 gives p1 = 0
      send_row({32'h0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                32'h0, 32'h0001_0000}, 1'b0);
      send_row({32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                32'h0, 32'h0001_0000}, 1'b0);
      send_row({32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                32'h0, 32'h0003_0000}, 1'b1);
      drain();
   endtask

   // more rows than the store holds; the extra rows are dropped and flagged
   task automatic test_too_many_rows();
      for (int k = 0; k < MAX_ROWS + 2; k++) begin
         send_row(k == 3 ? {tame_row()} & ~256'h0 : tame_row(), k == MAX_ROWS + 1);
      end
      drain();
      // a zero pivot on row zero, met before the overflow, keeps the pivot status
      for (int k = 0; k < MAX_ROWS + 1; k++) begin
         send_row(k == 0 ? tame_row() & {{(REQ_DATA_W-2*WORD_W){1'b1}}, {(2*WORD_W){1'b0}}}
                         : tame_row(), k == MAX_ROWS);
      end
      drain();
   endtask

   // receiver stalls for a long stretch while rows keep coming
   task automatic test_backpressure();
      hold_cycles = 3000;
      send_run(6, 1'b1);
      send_run(20, 1'b1);
      send_run(3, 1'b1);
      drain();
   endtask

   // mostly well-formed systems of random size, some noise rows
   task automatic test_random_runs();
      int sent;
      sent = 0;
      while (sent < 130) begin
         int rows;
         rows = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(8, 1);
         send_run(rows, $urandom_range(4) != 0);
         sent += rows;
         if (sent > 40 && sent < 100) idling = 1'b0;   // stretch with no gaps at all
         else idling = 1'b1;
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_row();
      test_extremes();
      test_zero_pivot();
      test_too_many_rows();
      test_backpressure();
      test_random_runs();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
